// File: sv/lbs_pkg.sv
package lbs_pkg;

	localparam int COORD_W = 12;
	localparam int COLOR_W = 8;
	localparam int ADDR_W  = 20;
	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef struct packed {
		logic we;
		logic last;
		logic rej;
	} pix_flags_t;

endpackage

// File: sv/lbs_req_if.sv
interface lbs_req_if;
	import lbs_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [COLOR_W-1:0] draw_color;

	modport source (
		output valid, req_type, start_x, start_y, end_x, end_y, draw_color,
		input ready
	);
	modport sink (
		input valid, req_type, start_x, start_y, end_x, end_y, draw_color,
		output ready
	);

endinterface

// File: sv/lbs_res_if.sv
interface lbs_res_if;
	import lbs_pkg::*;

	logic              valid;
	logic              ready;
	logic              write_enable;
	logic [ADDR_W-1:0] pixel_address;
	logic [COLOR_W-1:0] pixel_value;
	logic              last_pixel;
	logic              rejected;

	modport source (
		output valid, write_enable, pixel_address, pixel_value, last_pixel, rejected,
		input ready
	);
	modport sink (
		input valid, write_enable, pixel_address, pixel_value, last_pixel, rejected,
		output ready
	);

endinterface

// File: sv/bresenham_line_pixel_stepper.sv
// A request is registered in stage 1, stage 2 and then the result register.
// One request per cycle unless results stall; each yields exactly one result.
// Stepping state is registered on each advance, so ticks may follow back to back.
// The address multiply is combinational between stage 2 and the result register.
// Reset clears every valid flag and the active flag; the screen becomes 320 by 240.
module bresenham_line_pixel_stepper #(
	parameter int MAX_WIDTH  = lbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbs_pkg::CFG_W-1:0]     cfg_data,
	lbs_req_if.sink                       req,
	lbs_res_if.source                     res
);
	import lbs_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int EW_W  = $clog2(MAX_WIDTH + 1);
	localparam int EH_W  = $clog2(MAX_HEIGHT + 1);

	logic [CFG_W-1:0]   screen_width_q, screen_height_q;
	logic [EW_W-1:0]    eff_width;
	logic [EH_W-1:0]    eff_height;
	logic               pix_valid_s2, pix_ready;
	pix_flags_t         pix_flags_s2;
	logic [COL_W-1:0]   pix_col_s2;
	logic [ROW_W-1:0]   pix_row_s2;
	logic [COLOR_W-1:0] pix_color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Settings above the supported maximum behave as that maximum.
	assign eff_width  = (32'(screen_width_q) > MAX_WIDTH) ? EW_W'(MAX_WIDTH)
		: EW_W'(screen_width_q);
	assign eff_height = (32'(screen_height_q) > MAX_HEIGHT) ? EH_W'(MAX_HEIGHT)
		: EH_W'(screen_height_q);

	lbs_step #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.eff_width    (eff_width),
		.eff_height   (eff_height),
		.pix_valid_s2 (pix_valid_s2),
		.pix_ready    (pix_ready),
		.pix_flags_s2 (pix_flags_s2),
		.pix_col_s2   (pix_col_s2),
		.pix_row_s2   (pix_row_s2),
		.pix_color_s2 (pix_color_s2)
	);

	lbs_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.eff_width    (eff_width),
		.pix_valid_s2 (pix_valid_s2),
		.pix_ready    (pix_ready),
		.pix_flags_s2 (pix_flags_s2),
		.pix_col_s2   (pix_col_s2),
		.pix_row_s2   (pix_row_s2),
		.pix_color_s2 (pix_color_s2),
		.res          (res)
	);

endmodule

// File: sv/lbs_step.sv
module lbs_step #(
	parameter int MAX_WIDTH  = lbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbs_pkg::MAX_HEIGHT_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT),
	localparam int EW_W  = $clog2(MAX_WIDTH + 1),
	localparam int EH_W  = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	lbs_req_if.sink                 req,
	input  logic [EW_W-1:0]         eff_width,
	input  logic [EH_W-1:0]         eff_height,
	output logic                    pix_valid_s2,
	input  logic                    pix_ready,
	output lbs_pkg::pix_flags_t     pix_flags_s2,
	output logic [COL_W-1:0]        pix_col_s2,
	output logic [ROW_W-1:0]        pix_row_s2,
	output logic [lbs_pkg::COLOR_W-1:0] pix_color_s2
);
	import lbs_pkg::*;

	localparam int TW    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
	localparam int ERR_W = TW + 2;

	logic               valid_s1;
	logic               req_type_s1;
	logic [COORD_W-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COLOR_W-1:0] color_s1;

	logic                    active_q;
	logic [COL_W-1:0]        col_q, goal_col_q;
	logic [ROW_W-1:0]        row_q, goal_row_q;
	logic signed [ERR_W-1:0] err_q;
	logic [TW-1:0]           tdx_q, tdy_q;
	logic                    col_neg_q, row_neg_q, xmaj_q;
	logic [COLOR_W-1:0]      color_q;

	logic                    active_n;
	logic [COL_W-1:0]        col_n, goal_col_n;
	logic [ROW_W-1:0]        row_n, goal_row_n;
	logic signed [ERR_W-1:0] err_n;
	logic [TW-1:0]           tdx_n, tdy_n;
	logic                    col_neg_n, row_neg_n, xmaj_n;
	logic [COLOR_W-1:0]      color_n;
	pix_flags_t              flags_n;

	logic                    s2_free, s1_free, adv1;
	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        adx, ady;
	logic                    inside_all;
	logic signed [ERR_W-1:0] err_a;

	function automatic logic in_range(input logic [COORD_W-1:0] v, input logic [13:0] lim);
		in_range = !v[COORD_W-1] && (14'(v[COORD_W-2:0]) < lim);
	endfunction

	assign s2_free   = !pix_valid_s2 || pix_ready;
	assign adv1      = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s2_free;
	assign req.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && req.valid) begin
			req_type_s1 <= req.req_type;
			x0_s1       <= req.start_x;
			y0_s1       <= req.start_y;
			x1_s1       <= req.end_x;
			y1_s1       <= req.end_y;
			color_s1    <= req.draw_color;
		end
	end

	assign dx  = {x1_s1[COORD_W-1], x1_s1} - {x0_s1[COORD_W-1], x0_s1};
	assign dy  = {y1_s1[COORD_W-1], y1_s1} - {y0_s1[COORD_W-1], y0_s1};
	assign adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
	assign ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;

	assign inside_all = in_range(x0_s1, 14'(eff_width)) && in_range(x1_s1, 14'(eff_width))
		&& in_range(y0_s1, 14'(eff_height)) && in_range(y1_s1, 14'(eff_height));

	assign err_a = xmaj_q ? (err_q[ERR_W-1] ? err_q : err_q - ERR_W'(tdx_q))
		: (err_q[ERR_W-1] ? err_q : err_q - ERR_W'(tdy_q));

	always_comb begin
		active_n   = active_q;
		col_n      = col_q;
		row_n      = row_q;
		goal_col_n = goal_col_q;
		goal_row_n = goal_row_q;
		err_n      = err_q;
		tdx_n      = tdx_q;
		tdy_n      = tdy_q;
		col_neg_n  = col_neg_q;
		row_neg_n  = row_neg_q;
		xmaj_n     = xmaj_q;
		color_n    = color_q;
		flags_n    = '0;
		if (req_type_s1 == REQ_START) begin
			if (!inside_all) begin
				active_n    = 1'b0;
				flags_n.rej = 1'b1;
			end else begin
				color_n    = color_s1;
				col_n      = x0_s1[COL_W-1:0];
				row_n      = y0_s1[ROW_W-1:0];
				goal_col_n = x1_s1[COL_W-1:0];
				goal_row_n = y1_s1[ROW_W-1:0];
				col_neg_n  = dx[COORD_W];
				row_neg_n  = dy[COORD_W];
				tdx_n      = {adx[TW-2:0], 1'b0};
				tdy_n      = {ady[TW-2:0], 1'b0};
				xmaj_n     = adx > ady;
				if (xmaj_n) begin
					err_n = ERR_W'(tdy_n) - ERR_W'(adx);
				end else begin
					err_n = ERR_W'(tdx_n) - ERR_W'(ady);
				end
				flags_n.we   = 1'b1;
				flags_n.last = xmaj_n ? (x0_s1 == x1_s1) : (y0_s1 == y1_s1);
				active_n     = !flags_n.last;
			end
		end else if (active_q) begin
			if (xmaj_q) begin
				if (!err_q[ERR_W-1]) begin
					row_n = row_neg_q ? row_q - 1'b1 : row_q + 1'b1;
				end
				col_n = col_neg_q ? col_q - 1'b1 : col_q + 1'b1;
				err_n = err_a + ERR_W'(tdy_q);
			end else begin
				if (!err_q[ERR_W-1]) begin
					col_n = col_neg_q ? col_q - 1'b1 : col_q + 1'b1;
				end
				row_n = row_neg_q ? row_q - 1'b1 : row_q + 1'b1;
				err_n = err_a + ERR_W'(tdx_q);
			end
			flags_n.we   = 1'b1;
			flags_n.last = xmaj_q ? (col_n == goal_col_q) : (row_n == goal_row_q);
			active_n     = !flags_n.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			pix_valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				active_q <= active_n;
			end
			if (s2_free) begin
				pix_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			col_q      <= col_n;
			row_q      <= row_n;
			goal_col_q <= goal_col_n;
			goal_row_q <= goal_row_n;
			err_q      <= err_n;
			tdx_q      <= tdx_n;
			tdy_q      <= tdy_n;
			col_neg_q  <= col_neg_n;
			row_neg_q  <= row_neg_n;
			xmaj_q     <= xmaj_n;
			color_q    <= color_n;

			pix_flags_s2 <= flags_n;
			pix_col_s2   <= flags_n.we ? col_n : '0;
			pix_row_s2   <= flags_n.we ? row_n : '0;
			pix_color_s2 <= flags_n.we ? color_n : '0;
		end
	end

endmodule

// File: sv/lbs_addr.sv
module lbs_addr #(
	parameter int MAX_WIDTH  = lbs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lbs_pkg::MAX_HEIGHT_DEF,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT),
	localparam int EW_W  = $clog2(MAX_WIDTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [EW_W-1:0]         eff_width,
	input  logic                    pix_valid_s2,
	output logic                    pix_ready,
	input  lbs_pkg::pix_flags_t     pix_flags_s2,
	input  logic [COL_W-1:0]        pix_col_s2,
	input  logic [ROW_W-1:0]        pix_row_s2,
	input  logic [lbs_pkg::COLOR_W-1:0] pix_color_s2,
	lbs_res_if.source               res
);
	import lbs_pkg::*;

	localparam int PROD_W = ROW_W + EW_W + 1;
	localparam int SUM_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

	logic [SUM_W-1:0] sum;

	assign pix_ready = !res.valid || res.ready;
	assign sum = SUM_W'(pix_row_s2) * SUM_W'(eff_width) + SUM_W'(pix_col_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (pix_ready) begin
			res.valid <= pix_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid_s2) begin
			res.write_enable  <= pix_flags_s2.we;
			res.pixel_address <= pix_flags_s2.we ? sum[ADDR_W-1:0] : '0;
			res.pixel_value   <= pix_color_s2;
			res.last_pixel    <= pix_flags_s2.last;
			res.rejected      <= pix_flags_s2.rej;
		end
	end

endmodule

// File: sim/lbs_pixel_monitor.sv
`timescale 1ns / 100ps

module lbs_pixel_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbs_pkg::CFG_W-1:0]     cfg_data,
	lbs_req_if                            req,
	lbs_res_if                            res,
	output int                            mismatches,
	output int                            outstanding
);
	import lbs_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH_DEF);
	localparam int ROW_W = $clog2(MAX_HEIGHT_DEF);

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic               last;
		logic               rej;
	} pixel_write_t;

	logic [CFG_W-1:0]     screen_w;
	logic [CFG_W-1:0]     screen_h;
	logic                 drawing;
	logic [COL_W-1:0]     pos_col;
	logic [ROW_W-1:0]     pos_row;
	logic [COL_W-1:0]     end_col;
	logic [ROW_W-1:0]     end_row;
	logic signed [COORD_W:0] err_acc;
	logic [COORD_W-1:0]   span2_col;
	logic [COORD_W-1:0]   span2_row;
	logic                 col_dec;
	logic                 row_dec;
	logic                 col_major;
	logic [ADDR_W-1:0]    pos_addr;
	logic [COLOR_W-1:0]   line_color;

	pixel_write_t pixel_q[$];

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	// Advances the line state by one request and returns the pixel write it produces.
	function automatic pixel_write_t next_pixel(input logic kind,
			input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
			input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
			input logic [COLOR_W-1:0] c);
		int w, h, x0, y0, x1, y1, dx, dy, e, cc, rr, tdx, tdy;
		logic reached;
		pixel_write_t p;
		w = clamp_dim(screen_w, MAX_WIDTH_DEF);
		h = clamp_dim(screen_h, MAX_HEIGHT_DEF);
		p = '0;
		if (kind == REQ_START) begin
			x0 = int'($signed(sx));
			y0 = int'($signed(sy));
			x1 = int'($signed(ex));
			y1 = int'($signed(ey));
			if (x0 < 0 || x0 > w - 1 || x1 < 0 || x1 > w - 1 ||
					y0 < 0 || y0 > h - 1 || y1 < 0 || y1 > h - 1) begin
				drawing = 1'b0;
				p.rej = 1'b1;
				return p;
			end
			line_color = c;
			cc = x0;
			rr = y0;
			end_col = COL_W'(x1);
			end_row = ROW_W'(y1);
			dx = x1 - x0;
			dy = y1 - y0;
			col_dec = dx < 0;
			row_dec = dy < 0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			tdx = 2 * dx;
			tdy = 2 * dy;
			span2_col = COORD_W'(tdx);
			span2_row = COORD_W'(tdy);
			col_major = tdx > tdy;
			e = col_major ? tdy - dx : tdx - dy;
		end else if (!drawing) begin
			return p;
		end else begin
			cc = int'(pos_col);
			rr = int'(pos_row);
			e = int'(err_acc);
			tdx = int'(span2_col);
			tdy = int'(span2_row);
			if (col_major) begin
				if (e >= 0) begin
					rr += row_dec ? -1 : 1;
					e -= tdx;
				end
				cc += col_dec ? -1 : 1;
				e += tdy;
			end else begin
				if (e >= 0) begin
					cc += col_dec ? -1 : 1;
					e -= tdy;
				end
				rr += row_dec ? -1 : 1;
				e += tdx;
			end
		end
		pos_col = COL_W'(cc);
		pos_row = ROW_W'(rr);
		err_acc = (COORD_W+1)'(e);
		pos_addr = ADDR_W'(rr * w + cc);
		reached = col_major ? (pos_col == end_col) : (pos_row == end_row);
		drawing = !reached;
		p.we = 1'b1;
		p.addr = pos_addr;
		p.value = line_color;
		p.last = reached;
		return p;
	endfunction

	task automatic report(input string msg);
		if (mismatches < 40)
			$display("%0t ns: pixel mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_write_t got;
		pixel_write_t want;
		if (!arst_n) begin
			screen_w = SCREEN_WIDTH_RST;
			screen_h = SCREEN_HEIGHT_RST;
			drawing = 1'b0;
			pos_col = '0;
			pos_row = '0;
			end_col = '0;
			end_row = '0;
			err_acc = '0;
			span2_col = '0;
			span2_row = '0;
			col_dec = 1'b0;
			row_dec = 1'b0;
			col_major = 1'b0;
			pos_addr = '0;
			line_color = '0;
			pixel_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: screen_w = cfg_data;
					REG_SCREEN_HEIGHT: screen_h = cfg_data;
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got.we = res.write_enable;
				got.addr = res.pixel_address;
				got.value = res.pixel_value;
				got.last = res.last_pixel;
				got.rej = res.rejected;
				if (pixel_q.size() == 0) begin
					report("result transfer with no request pending");
				end else begin
					want = pixel_q.pop_front();
					if (got.we !== want.we)
						report($sformatf("write_enable %b, expected %b", got.we, want.we));
					if (got.addr !== want.addr)
						report($sformatf("pixel_address %0d, expected %0d",
							got.addr, want.addr));
					if (got.value !== want.value)
						report($sformatf("pixel_value %0h, expected %0h",
							got.value, want.value));
					if (got.last !== want.last)
						report($sformatf("last_pixel %b, expected %b", got.last, want.last));
					if (got.rej !== want.rej)
						report($sformatf("rejected %b, expected %b", got.rej, want.rej));
				end
			end
			if (req.valid && req.ready)
				pixel_q.push_back(next_pixel(req.req_type, req.start_x, req.start_y,
					req.end_x, req.end_y, req.draw_color));
			outstanding <= pixel_q.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lbs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   send_gap_pct;
	int                   stall_pct;
	int                   items_left;
	int                   scr_w;
	int                   scr_h;
	int                   cycle_count = 0;

	lbs_req_if req_ch();
	lbs_res_if res_ch();

	bresenham_line_pixel_stepper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	lbs_pixel_monitor pixel_mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.res         (res_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_req(input logic kind,
			input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
			input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
			input logic [COLOR_W-1:0] c);
		while ($urandom_range(99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.start_x <= sx;
		req_ch.start_y <= sy;
		req_ch.end_x <= ex;
		req_ch.end_y <= ey;
		req_ch.draw_color <= c;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		items_left--;
	endtask

	task automatic start_line(input int x0, input int y0, input int x1, input int y1,
			input logic [COLOR_W-1:0] c);
		send_req(REQ_START, x0[COORD_W-1:0], y0[COORD_W-1:0], x1[COORD_W-1:0],
			y1[COORD_W-1:0], c);
	endtask

	// Coordinates and color of a tick are don't-care, so they carry noise.
	task automatic tick();
		send_req(REQ_TICK, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), COLOR_W'($urandom));
	endtask

	task automatic set_screen(input int w, input int h);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		scr_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
		scr_h = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic int pick_coord(input int lim);
		int r;
		if (lim <= 1) return 0;
		r = $urandom_range(7);
		if (r == 0) return 0;
		if (r == 1) return lim - 1;
		return $urandom_range(lim - 1, 0);
	endfunction

	function automatic int nudge(input int base, input int lim);
		int v;
		v = base + int'($urandom_range(16)) - 8;
		if (v < 0) v = 0;
		if (v > lim - 1) v = lim - 1;
		return v;
	endfunction

	task automatic random_line();
		int x0, y0, x1, y1, span, dy, ticks;
		x0 = pick_coord(scr_w);
		y0 = pick_coord(scr_h);
		if ($urandom_range(19) == 0) begin
			x1 = pick_coord(scr_w);
			y1 = pick_coord(scr_h);
		end else begin
			x1 = nudge(x0, scr_w);
			y1 = nudge(y0, scr_h);
		end
		span = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		if (dy > span) span = dy;
		ticks = span;
		case ($urandom_range(9))
			0: ticks = $urandom_range(span, 0);
			1: ticks = span + $urandom_range(3, 1);
			default: ;
		endcase
		start_line(x0, y0, x1, y1, COLOR_W'($urandom));
		for (int i = 0; i < ticks && items_left > 0; i++)
			tick();
	endtask

	task automatic noise_item();
		int x0, y0, x1, y1;
		case ($urandom_range(3))
			0: tick();
			1: send_req(REQ_START, COORD_W'($urandom), COORD_W'($urandom),
				COORD_W'($urandom), COORD_W'($urandom), COLOR_W'($urandom));
			default: begin
				x0 = pick_coord(scr_w);
				y0 = pick_coord(scr_h);
				x1 = pick_coord(scr_w);
				y1 = pick_coord(scr_h);
				case ($urandom_range(3))
					0: x0 = -1;
					1: x1 = scr_w;
					2: y0 = scr_h;
					default: y1 = int'($urandom_range(2047)) - 2048;
				endcase
				start_line(x0, y0, x1, y1, COLOR_W'($urandom));
			end
		endcase
	endtask

	initial begin
		int widths[PHASES];
		int heights[PHASES];
		widths = '{320, 1, 2047, 0, 1024, 7, 0, 40, 0};
		heights = '{240, 1, 2047, 240, 1024, 3, 0, 1024, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SCREEN_WIDTH;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_START;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		req_ch.draw_color = '0;
		send_gap_pct = 0;
		stall_pct = 0;
		items_left = 0;
		scr_w = SCREEN_WIDTH_RST;
		scr_h = SCREEN_HEIGHT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tick();
		start_line(0, 0, 0, 0, 8'hFF);
		start_line(319, 239, 319, 239, 8'h00);
		start_line(-1, 0, 5, 5, 8'h11);
		tick();
		start_line(2047, -2048, 0, 0, 8'h22);
		start_line(0, 0, -2048, 2047, 8'h33);
		start_line(0, 0, 320, 0, 8'h44);
		start_line(0, 0, 0, 240, 8'h55);
		start_line(0, 0, 3, 1, 8'h5A);
		repeat (3) tick();
		tick();
		start_line(5, 5, 2, 9, 8'hA5);
		tick();
		start_line(10, 10, 8, 8, 8'h3C);
		repeat (2) tick();
		start_line(318, 1, 319, 0, 8'hC3);
		tick();
		drain();

		for (int k = 0; k < PHASES; k++) begin
			if (k > 0) begin
				if (widths[k] == 0 && heights[k] == 0)
					set_screen($urandom_range(1100, 1), $urandom_range(1100, 1));
				else
					set_screen(widths[k], heights[k]);
			end
			send_gap_pct = (k % 4 == 1) ? 48 : (k % 4 == 3) ? 37 : 0;
			stall_pct = (k % 4 == 2) ? 48 : (k % 4 == 3) ? 37 : 0;
			items_left = PHASE_ITEMS;
			while (items_left > 0) begin
				if (scr_w == 0 || scr_h == 0 || $urandom_range(99) < 15)
					noise_item();
				else
					random_line();
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
